// ===== design/satm_pkg.sv =====
package satm_pkg;

	localparam int NUM_SETS = 256;
	localparam int NUM_WAYS = 8;
	localparam int SET_W = $clog2(NUM_SETS);
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int CNT_W = $clog2(NUM_WAYS + 1);
	localparam int TAG_W = 30;
	localparam int IDX_W = 3;
	localparam int CFG_W = 9;
	localparam int QDEPTH = 2;
	localparam logic [15:0] MEM_COST = 16'd100;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	typedef enum logic [IDX_W-1:0] {
		REG_ALLOC = 3'd0,
		REG_WB    = 3'd1,
		REG_FIFO  = 3'd2,
		REG_WAYS  = 3'd3,
		REG_WORDS = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ACCT
	} state_t;

	typedef struct packed {
		logic             mode;
		logic [SET_W-1:0] set;
		logic [TAG_W-1:0] tag;
	} item_t;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [WAY_W-1:0] age;
		logic [TAG_W-1:0] tag;
	} way_t;

	typedef way_t [NUM_WAYS-1:0] row_t;

endpackage

// ===== design/set_assoc_cache_timing_model_top.sv =====
// channel   dir  handshake                   payload
// access    in   start & !busy               mode, set_index, tag
// result    out  done (one cycle, no stall)  hit, victim_dirty, access_cycles, totals
// config    in   cfg_we                      cfg_index, cfg_data
//
// A transaction is popped once the back end is idle or in its counter update, and
// its set is read at the pop; it then passes through compare and update (EVAL)
// and the counter update (ACCT). done is registered from ACCT, so it is high in
// the cycle after the counter update. The set read of the next transaction
// overlaps the counter update. Transactions enter a two-entry queue, so busy rises
// only with two transactions waiting. Reset clears valid and dirty state of all
// 256 sets at once (per-set valid flops) and loads the configuration defaults.
module set_assoc_cache_timing_model_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [7:0]                    set_index,
	input  logic [29:0]                   tag,
	input  logic                          cfg_we,
	input  logic [satm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [satm_pkg::CFG_W-1:0]    cfg_data,
	output logic                          done,
	output logic                          hit,
	output logic                          victim_dirty,
	output logic [15:0]                   access_cycles,
	output logic [47:0]                   total_cycles,
	output logic [31:0]                   load_count,
	output logic [31:0]                   store_count,
	output logic [31:0]                   load_hit_count,
	output logic [31:0]                   load_miss_count,
	output logic [31:0]                   store_hit_count,
	output logic [31:0]                   store_miss_count
);

	logic            pop;
	logic            avail;
	satm_pkg::item_t head;

	satm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.set_index (set_index),
		.tag       (tag),
		.pop       (pop),
		.avail     (avail),
		.head      (head)
	);

	satm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.avail            (avail),
		.head             (head),
		.pop              (pop),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.done             (done),
		.hit              (hit),
		.victim_dirty     (victim_dirty),
		.access_cycles    (access_cycles),
		.total_cycles     (total_cycles),
		.load_count       (load_count),
		.store_count      (store_count),
		.load_hit_count   (load_hit_count),
		.load_miss_count  (load_miss_count),
		.store_hit_count  (store_hit_count),
		.store_miss_count (store_miss_count)
	);

endmodule

// ===== design/satm_front.sv =====
module satm_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   mode,
	input  logic [7:0]             set_index,
	input  logic [29:0]            tag,
	input  logic                   pop,
	output logic                   avail,
	output satm_pkg::item_t        head
);

	satm_pkg::item_t entry_q [satm_pkg::QDEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            do_pop;

	assign busy   = (count_q == 2'(satm_pkg::QDEPTH));
	assign avail  = (count_q != 2'd0);
	assign push   = start && !busy;
	assign do_pop = pop && avail;
	assign head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q].mode <= mode;
			entry_q[wr_ptr_q].set  <= set_index[satm_pkg::SET_W-1:0];
			entry_q[wr_ptr_q].tag  <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(satm_pkg::QDEPTH)) else $error("queue overflow");
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && count_q == 2'd1) |=> !avail) else $error("queue drain");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1 && push && !do_pop) |=> busy) else $error("queue fill");
`endif

endmodule

// ===== design/satm_back.sv =====
module satm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          avail,
	input  satm_pkg::item_t               head,
	output logic                          pop,
	input  logic                          cfg_we,
	input  logic [satm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [satm_pkg::CFG_W-1:0]    cfg_data,
	output logic                          done,
	output logic                          hit,
	output logic                          victim_dirty,
	output logic [15:0]                   access_cycles,
	output logic [47:0]                   total_cycles,
	output logic [31:0]                   load_count,
	output logic [31:0]                   store_count,
	output logic [31:0]                   load_hit_count,
	output logic [31:0]                   load_miss_count,
	output logic [31:0]                   store_hit_count,
	output logic [31:0]                   store_miss_count
);

	localparam int NW = satm_pkg::NUM_WAYS;
	localparam int WW = satm_pkg::WAY_W;
	localparam int CW = satm_pkg::CNT_W;

	satm_pkg::state_t state_q, state_d;

	logic       alloc_q, wb_q, fifo_q;
	logic [3:0] ways_q;
	logic [8:0] words_q;

	satm_pkg::row_t mem [satm_pkg::NUM_SETS];
	logic           rowv_q [satm_pkg::NUM_SETS];

	satm_pkg::row_t               rd_s2;
	logic                         rowok_s2;
	logic [satm_pkg::SET_W-1:0]   set_s2;
	logic [satm_pkg::TAG_W-1:0]   tag_s2;
	logic                         store_s2;

	logic        hit_s3, vd_s3, store_s3;
	logic [16:0] cost_s3;

	logic        done_q, hit_q, vd_q;
	logic [15:0] cost_q;
	logic [47:0] total_q;
	logic [31:0] loads_q, stores_q, lhit_q, lmiss_q, shit_q, smiss_q;

	logic [CW-1:0]  nw, c;
	logic [NW-1:0]  act, vld, match;
	satm_pkg::row_t cur, nrow;
	logic           hit_c, full, do_place, do_young, vd_c;
	logic [WW-1:0]  hw, fv, vic, pw, yw, old_age;
	logic [16:0]    w100, wext, cost_c;
	logic [48:0]    sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= 1'b1;
			wb_q    <= 1'b1;
			fifo_q  <= 1'b0;
			ways_q  <= 4'd8;
			words_q <= 9'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				satm_pkg::REG_ALLOC: alloc_q <= cfg_data[0];
				satm_pkg::REG_WB:    wb_q    <= cfg_data[0];
				satm_pkg::REG_FIFO:  fifo_q  <= cfg_data[0];
				satm_pkg::REG_WAYS:  ways_q  <= cfg_data[3:0];
				satm_pkg::REG_WORDS: words_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= satm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			satm_pkg::ST_IDLE: begin
				if (avail) begin
					pop     = 1'b1;
					state_d = satm_pkg::ST_EVAL;
				end
			end
			satm_pkg::ST_EVAL: state_d = satm_pkg::ST_ACCT;
			satm_pkg::ST_ACCT: begin
				if (avail) begin
					pop     = 1'b1;
					state_d = satm_pkg::ST_EVAL;
				end else begin
					state_d = satm_pkg::ST_IDLE;
				end
			end
			default: state_d = satm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s2    <= mem[head.set];
			set_s2   <= head.set;
			tag_s2   <= head.tag;
			store_s2 <= head.mode;
		end
		if (state_q == satm_pkg::ST_EVAL)
			mem[set_s2] <= nrow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < satm_pkg::NUM_SETS; i++)
				rowv_q[i] <= 1'b0;
			rowok_s2 <= 1'b0;
		end else begin
			if (pop)
				rowok_s2 <= rowv_q[head.set];
			if (state_q == satm_pkg::ST_EVAL)
				rowv_q[set_s2] <= 1'b1;
		end
	end

	always_comb begin
		if (ways_q == 4'd0)
			nw = CW'(1);
		else if (32'(ways_q) > NW)
			nw = CW'(NW);
		else
			nw = CW'(ways_q);

		cur   = rd_s2;
		c     = '0;
		hit_c = 1'b0;
		hw    = '0;
		fv    = '0;
		for (int w = 0; w < NW; w++) begin
			act[w]       = (CW'(w) < nw);
			cur[w].valid = rd_s2[w].valid && rowok_s2;
			cur[w].dirty = rd_s2[w].dirty && rowok_s2;
			vld[w]       = act[w] && cur[w].valid;
			match[w]     = vld[w] && (cur[w].tag == tag_s2);
			c            = c + CW'(vld[w]);
		end
		for (int w = NW - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_c = 1'b1;
				hw    = WW'(w);
			end
			if (act[w] && !cur[w].valid)
				fv = WW'(w);
		end
		vic = '0;
		for (int w = 1; w < NW; w++)
			if (act[w] && cur[w].age < cur[vic].age)
				vic = WW'(w);

		full     = (c == nw);
		do_place = !hit_c && (!store_s2 || alloc_q);
		pw       = full ? vic : fv;
		yw       = hit_c ? hw : vic;
		do_young = (hit_c && !fifo_q) || (do_place && full);
		vd_c     = do_place && full && cur[vic].dirty;
		old_age  = cur[yw].age;

		nrow = cur;
		if (do_young) begin
			for (int w = 0; w < NW; w++)
				if (WW'(w) != yw && vld[w] && cur[w].age > old_age)
					nrow[w].age = cur[w].age - WW'(1);
			nrow[yw].age = WW'(c - CW'(1));
		end
		if (hit_c && store_s2 && wb_q)
			nrow[hw].dirty = 1'b1;
		if (do_place) begin
			nrow[pw].valid = 1'b1;
			nrow[pw].tag   = tag_s2;
			nrow[pw].dirty = 1'b0;
			if (!full)
				nrow[pw].age = WW'(c);
		end

		wext = 17'(words_q);
		w100 = wext * 17'(satm_pkg::MEM_COST);
		if (!store_s2)
			cost_c = hit_c ? wext : (w100 + wext);
		else if (hit_c)
			cost_c = wb_q ? 17'd1 : (17'(satm_pkg::MEM_COST) + 17'd1);
		else if (alloc_q)
			cost_c = w100 + 17'(satm_pkg::MEM_COST) + 17'd1;
		else
			cost_c = 17'(satm_pkg::MEM_COST);
		if (vd_c)
			cost_c = cost_c + w100;
	end

	always_ff @(posedge clk) begin
		if (state_q == satm_pkg::ST_EVAL) begin
			hit_s3   <= hit_c;
			vd_s3    <= vd_c;
			store_s3 <= store_s2;
			cost_s3  <= cost_c;
		end
	end

	assign sum = 49'(total_q) + 49'(cost_s3);

	always_ff @(posedge clk) begin
		if (state_q == satm_pkg::ST_ACCT) begin
			hit_q  <= hit_s3;
			vd_q   <= vd_s3;
			cost_q <= cost_s3[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			total_q <= '0;
			loads_q <= '0;
			stores_q <= '0;
			lhit_q  <= '0;
			lmiss_q <= '0;
			shit_q  <= '0;
			smiss_q <= '0;
		end else begin
			done_q <= (state_q == satm_pkg::ST_ACCT);
			if (state_q == satm_pkg::ST_ACCT) begin
				total_q <= (sum > 49'(satm_pkg::MAX48)) ? satm_pkg::MAX48 : sum[47:0];
				if (!store_s3) begin
					if (loads_q != satm_pkg::MAX32) loads_q <= loads_q + 32'd1;
					if (hit_s3 && lhit_q != satm_pkg::MAX32) lhit_q <= lhit_q + 32'd1;
					if (!hit_s3 && lmiss_q != satm_pkg::MAX32) lmiss_q <= lmiss_q + 32'd1;
				end else begin
					if (stores_q != satm_pkg::MAX32) stores_q <= stores_q + 32'd1;
					if (hit_s3 && shit_q != satm_pkg::MAX32) shit_q <= shit_q + 32'd1;
					if (!hit_s3 && smiss_q != satm_pkg::MAX32) smiss_q <= smiss_q + 32'd1;
				end
			end
		end
	end

	assign done             = done_q;
	assign hit              = hit_q;
	assign victim_dirty     = vd_q;
	assign access_cycles    = cost_q;
	assign total_cycles     = total_q;
	assign load_count       = loads_q;
	assign store_count      = stores_q;
	assign load_hit_count   = lhit_q;
	assign load_miss_count  = lmiss_q;
	assign store_hit_count  = shit_q;
	assign store_miss_count = smiss_q;

`ifndef SYNTHESIS
	a_done_after_acct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == satm_pkg::ST_ACCT) |=> done_q) else $error("missing result");
	a_vd_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(hit_q && vd_q)) else $error("dirty victim on hit");
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail) else $error("pop from empty queue");
	a_eval_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == satm_pkg::ST_EVAL)) else $error("lost transaction");
`endif

endmodule
